// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CRS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/crs_pkg.sv =====
// types and constants of the coalescing range set
// no dependencies
package crs_pkg;

  localparam int unsigned MAX_RANGES = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_RANGES);
  localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 33;
  localparam int unsigned END_W   = 33;
  localparam int unsigned WIDE_W  = 34;
  localparam int unsigned LIMIT_W = 33;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 33'h1_0000_0000;

  typedef struct packed {
    logic [END_W-1:0]  end_addr;
    logic [ADDR_W-1:0] start_addr;
  } crs_entry_t;

  localparam int unsigned ENTRY_W = $bits(crs_entry_t);

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_LIMIT = 2'd1,
    STATUS_FULL  = 2'd2
  } crs_status_e;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_QUERY  = 2'd1
  } crs_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE,
    ST_COLLAPSE,
    ST_SHIFT,
    ST_INSERT,
    ST_RESP
  } crs_state_e;

endpackage

// ===== rtl/core/crs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module crs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/coalescing_range_set.sv =====
// top level of the coalescing range set: sequencer, compare unit and table control
// depends on crs_pkg, crs_ram and assert_macros.svh
//
// Usage: each word on the slave stream is one command: s_axis_tuser[0] selects
// record (0) or query (1), s_axis_tdata carries address and size. Every command
// gives exactly one result word on the master stream: contained flag and status.
// The cfg write channel loads memory_limit; it is always ready and must only be
// written while no command is in flight.
// A single table ram port and one shared compare unit visit the stored ranges
// one per cycle. A query scans the table and then responds. A record scans the
// table, then either merges and compacts the tail or opens a slot by moving the
// entries above it up and writes the new range. Out-of-limit and zero size
// records skip the scan and go straight to the response; a full-table record
// responds right after its scan.
// One command is in work at a time; tready is high only while the sequencer
// is idle, but the finished result sits in an output register, so a stalled
// receiver blocks only the command after the one whose result is waiting.
// Reset empties the table (count zero, no clearing pass) and sets memory_limit
// to 2^32.
module coalescing_range_set
  import crs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write channel: memory_limit
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i,
  // slave stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [71:0]        s_axis_tdata,  // address[31:0], size[64:32], zero pad
  input  logic [0:0]         s_axis_tuser,  // cmd[0]
  // master stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata   // contained[0], status[2:1], zero pad
);

  crs_state_e         state_q, state_d;
  logic               is_query_q, is_query_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [WIDE_W-1:0]  end_q, end_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]   lo_q, lo_d;
  logic [CNT_W-1:0]   hi_q, hi_d;
  logic               merged_q, merged_d;
  logic [ADDR_W-1:0]  ns_q, ns_d;
  logic [END_W-1:0]   ne_q, ne_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               hit_q, hit_d;
  crs_status_e        status_q, status_d;
  logic [LIMIT_W-1:0] limit_q;
  logic               out_vld_q, out_vld_d;
  logic               out_hit_q, out_hit_d;
  crs_status_e        out_status_q, out_status_d;

  logic               ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
  logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
  crs_entry_t         rd_ent, wr_ent;

  logic               in_acc;
  logic [ADDR_W-1:0]  in_addr;
  logic [SIZE_W-1:0]  in_size;
  logic [WIDE_W-1:0]  in_end;
  logic               issue;
  logic [CNT_W-1:0]   gone;
  logic [CNT_W-1:0]   rd_idx_ext;
  logic [CNT_W-1:0]   ptr_dec;
  logic [CNT_W-1:0]   wr_pos;

  assign in_addr = s_axis_tdata[31:0];
  assign in_size = s_axis_tdata[64:32];
  assign in_end  = {2'b00, in_addr} + {1'b0, in_size};
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b00000, out_status_q, out_hit_q};

  assign rd_ent      = crs_entry_t'(ram_rd_data);
  assign ram_wr_data = ENTRY_W'(wr_ent);
  assign gone        = hi_q - lo_q - CNT_W'(1);
  assign rd_idx_ext  = CNT_W'(rd_idx_q);
  assign ptr_dec     = ptr_q - CNT_W'(1);

  crs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      limit_q      <= LIMIT_RESET;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rd_vld_q     <= rd_vld_d;
      out_vld_q    <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    is_query_q   <= is_query_d;
    addr_q       <= addr_d;
    end_q        <= end_d;
    ptr_q        <= ptr_d;
    rd_idx_q     <= rd_idx_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    merged_q     <= merged_d;
    ns_q         <= ns_d;
    ne_q         <= ne_d;
    hit_q        <= hit_d;
    status_q     <= status_d;
    out_hit_q    <= out_hit_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d      = state_q;
    is_query_d   = is_query_q;
    addr_d       = addr_q;
    end_d        = end_q;
    ptr_d        = ptr_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    merged_d     = merged_q;
    ns_d         = ns_q;
    ne_d         = ne_q;
    count_d      = count_q;
    hit_d        = hit_q;
    status_d     = status_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_hit_d    = out_hit_q;
    out_status_d = out_status_q;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = lo_q[IDX_W-1:0];
    wr_ent       = rd_ent;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = ptr_q[IDX_W-1:0];
    issue        = 1'b0;
    wr_pos       = rd_idx_ext;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          is_query_d = (s_axis_tuser[0] == CMD_QUERY[0]);
          addr_d     = in_addr;
          end_d      = in_end;
          ptr_d      = '0;
          lo_d       = '0;
          hi_d       = '0;
          merged_d   = 1'b0;
          hit_d      = 1'b0;
          status_d   = STATUS_OK;
          if (s_axis_tuser[0] == CMD_QUERY[0]) begin
            state_d = ST_SCAN;
          end else if (in_size == '0) begin
            state_d = ST_RESP;
          end else if (in_end > {1'b0, limit_q}) begin
            status_d = STATUS_LIMIT;
            state_d  = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        issue     = (ptr_q < count_q);
        ram_rd_en = issue;
        if (issue) begin
          ptr_d    = ptr_q + CNT_W'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_q[IDX_W-1:0];
        end
        if (rd_vld_q) begin
          if (is_query_q) begin
            if (addr_q >= rd_ent.start_addr && end_q <= {1'b0, rd_ent.end_addr}) begin
              hit_d = 1'b1;
            end
          end else if (rd_ent.end_addr < {1'b0, addr_q}) begin
            // entry lies wholly below the new range
            lo_d = rd_idx_ext + CNT_W'(1);
          end else if ({2'b00, rd_ent.start_addr} <= end_q) begin
            // overlaps or touches: fold into the merged range
            if (!merged_q) begin
              ns_d = (rd_ent.start_addr < addr_q) ? rd_ent.start_addr : addr_q;
            end
            merged_d = 1'b1;
            ne_d     = (rd_ent.end_addr > end_q[END_W-1:0]) ? rd_ent.end_addr
                                                            : end_q[END_W-1:0];
            hi_d     = rd_idx_ext + CNT_W'(1);
          end
        end
        if (!issue && !rd_vld_q) begin
          if (is_query_q) begin
            state_d = ST_RESP;
          end else if (merged_q) begin
            state_d = ST_MERGE;
          end else if (count_q == CNT_W'(MAX_RANGES)) begin
            status_d = STATUS_FULL;
            state_d  = ST_RESP;
          end else begin
            ptr_d   = count_q;
            state_d = ST_SHIFT;
          end
        end
      end

      ST_MERGE: begin
        ram_wr_en          = 1'b1;
        ram_wr_addr        = lo_q[IDX_W-1:0];
        wr_ent.start_addr  = ns_q;
        wr_ent.end_addr    = ne_q;
        ptr_d              = hi_q;
        state_d            = (gone == '0) ? ST_RESP : ST_COLLAPSE;
      end

      ST_COLLAPSE: begin
        // pull the tail down over the entries swallowed by the merge
        issue     = (ptr_q < count_q);
        ram_rd_en = issue;
        if (issue) begin
          ptr_d    = ptr_q + CNT_W'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_q[IDX_W-1:0];
        end
        if (rd_vld_q) begin
          wr_pos      = rd_idx_ext - gone;
          ram_wr_en   = 1'b1;
          ram_wr_addr = wr_pos[IDX_W-1:0];
        end
        if (!issue && !rd_vld_q) begin
          count_d = count_q - gone;
          state_d = ST_RESP;
        end
      end

      ST_SHIFT: begin
        // move entries at and above the slot up by one, top first
        issue       = (ptr_q > lo_q);
        ram_rd_en   = issue;
        ram_rd_addr = ptr_dec[IDX_W-1:0];
        if (issue) begin
          ptr_d    = ptr_dec;
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_dec[IDX_W-1:0];
        end
        if (rd_vld_q) begin
          wr_pos      = rd_idx_ext + CNT_W'(1);
          ram_wr_en   = 1'b1;
          ram_wr_addr = wr_pos[IDX_W-1:0];
        end
        if (!issue && !rd_vld_q) begin
          state_d = ST_INSERT;
        end
      end

      ST_INSERT: begin
        ram_wr_en         = 1'b1;
        ram_wr_addr       = lo_q[IDX_W-1:0];
        wr_ent.start_addr = addr_q;
        wr_ent.end_addr   = end_q[END_W-1:0];
        count_d           = count_q + CNT_W'(1);
        state_d           = ST_RESP;
      end

      ST_RESP: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d    = 1'b1;
          out_hit_d    = hit_q && is_query_q;
          out_status_d = status_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`include "assert_macros.svh"

  `CRS_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(MAX_RANGES), "range count beyond table depth")
  `CRS_ASSERT_NOW(a_read_below_count, clk_i, rst_ni, ram_rd_en, CNT_W'(ram_rd_addr) < count_q, "table read at or above the entry count")
  `CRS_ASSERT_NEXT(a_resp_loads_out, clk_i, rst_ni, (state_q == ST_RESP) && (!out_vld_q || m_axis_tready), m_axis_tvalid && (state_q == ST_IDLE), "result not presented after response state")

endmodule
